### src/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// assertion helpers; empty when synthesizing
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// property checked on every clock edge outside reset
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// implication checked on every clock edge outside reset
`define ASSERT_IMPL(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);
`else
`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_IMPL(lbl, pre, post, msg)
`endif

`endif

### src/bzc_pkg.sv
// ---------------------------------------------------------------------------
// bzc_pkg
// shared types and constants of the buzzer tone pattern controller
// ---------------------------------------------------------------------------
package bzc_pkg;

  // operation codes
  localparam logic [2:0] OP_TICK    = 3'd0;
  localparam logic [2:0] OP_PLAY    = 3'd1;
  localparam logic [2:0] OP_STOP    = 3'd2;
  localparam logic [2:0] OP_SUCCESS = 3'd3;
  localparam logic [2:0] OP_ERROR   = 3'd4;
  localparam logic [2:0] OP_WARNING = 3'd5;

  // status codes
  localparam logic [1:0] STS_OK    = 2'd0;
  localparam logic [1:0] STS_NOEN  = 2'd1;
  localparam logic [1:0] STS_INVAL = 2'd2;

  // pattern kinds
  localparam logic [1:0] PAT_NONE    = 2'd0;
  localparam logic [1:0] PAT_SUCCESS = 2'd1;
  localparam logic [1:0] PAT_ERROR   = 2'd2;
  localparam logic [1:0] PAT_WARNING = 2'd3;

  // register indexes
  localparam logic [2:0] REG_ENABLE = 3'd0;
  localparam logic [2:0] REG_VOLUME = 3'd1;
  localparam logic [2:0] REG_NOTE_HI = 3'd2;
  localparam logic [2:0] REG_NOTE_MID = 3'd3;
  localparam logic [2:0] REG_NOTE_LO = 3'd4;

  // reset values
  localparam logic [6:0]  VOLUME_RST  = 7'd50;
  localparam logic [14:0] NOTE_HI_RST = 15'd523;
  localparam logic [14:0] NOTE_MID_RST = 15'd330;
  localparam logic [14:0] NOTE_LO_RST = 15'd262;

  // limits and timing
  localparam logic [15:0] FREQ_MIN = 16'd20;
  localparam logic [15:0] FREQ_MAX = 16'd20000;
  localparam logic [7:0]  PCT      = 8'd100;
  localparam logic [7:0]  NOTE_DUTY = 8'd30;
  localparam logic [19:0] NOTE_SHORT_MS = 20'd40;
  localparam logic [19:0] NOTE_LONG_MS  = 20'd100;
  localparam logic [7:0]  GAP_SHORT = 8'd140;
  localparam logic [7:0]  GAP_LONG  = 8'd250;

  // serial divider sizes
  localparam int DIV_DW = 34;
  localparam int DIV_VW = 16;
  localparam logic [DIV_DW-1:0] NS_PER_S = 34'd1000000000;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SCALE, ST_PER, ST_MUL, ST_PUL, ST_FIN, ST_OUT
  } state_t;

  typedef struct packed {
    logic [2:0]  operation;
    logic [15:0] tone_freq;
    logic [7:0]  duty_percent;
    logic [19:0] tone_len;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [25:0] pwm_period;
    logic [25:0] pwm_pulse;
    logic        pwm_updated;
    logic        playing;
  } out_beat_t;

endpackage

### src/buzzer_tone_pattern_controller.sv
// ---------------------------------------------------------------------------
// buzzer_tone_pattern_controller
// tone requests, auto-stop countdown and beep pattern sequencer
// ---------------------------------------------------------------------------
// channel | direction | handshake              | payload
// in_     | input     | in_valid / in_stall    | in_data (in_beat_t)
// out_    | output    | out_valid / out_stall  | out_data (out_beat_t)
// cfg     | input     | psel/penable/pready    | paddr, pwdata, prdata
//
// beats that start no new tone go from accept through the fin and out states to their result
// a sounding tone runs the bit-serial divider 3 times (scale, period, pulse),
// then passes through the fin and out states to its result
// one beat is in flight at a time; in_stall is high until its result is taken
// reset is synchronous, active low, and restores the register defaults
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module buzzer_tone_pattern_controller (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  bzc_pkg::in_beat_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output bzc_pkg::out_beat_t out_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  import bzc_pkg::*;

  state_t state_r, state_nxt;

  // registers
  logic        enable_r;
  logic [6:0]  volume_r;
  logic [14:0] note_hi_r, note_mid_r, note_lo_r;

  // tone state
  logic        tone_on_r;
  logic [25:0] period_r, pulse_r;
  logic        armed_r;
  logic [19:0] remain_r;
  logic [1:0]  kind_r, index_r;
  logic [7:0]  gap_r;

  // per-beat work registers
  logic [1:0]  status_r;
  logic [25:0] old_per_r, old_pul_r;
  logic [15:0] freq_r;
  logic [19:0] dur_r;
  logic [6:0]  scaled_r;
  logic [25:0] per_r;
  logic        out_valid_r;
  out_beat_t   out_data_r;

  // decode results
  logic        d_tone_on, d_armed, d_req;
  logic [25:0] d_pulse;
  logic [19:0] d_remain, d_dur;
  logic [1:0]  d_kind, d_index, d_status;
  logic [7:0]  d_gap, d_duty;
  logic [15:0] d_freq;

  logic        accept, cfg_wr;
  logic        div_start, div_done;
  logic [DIV_DW-1:0] div_dividend, div_quo;
  logic [DIV_VW-1:0] div_divisor;

  assign accept = in_valid && !in_stall;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  // decode one beat against the current state
  always_comb begin : decode
    logic       step;
    logic [1:0] nidx;
    logic [1:0] last;
    logic [15:0] nfreq;
    d_tone_on = tone_on_r;
    d_pulse   = pulse_r;
    d_armed   = armed_r;
    d_remain  = remain_r;
    d_kind    = kind_r;
    d_index   = index_r;
    d_gap     = gap_r;
    d_status  = STS_OK;
    d_req     = 1'b0;
    d_freq    = in_data.tone_freq;
    d_duty    = in_data.duty_percent;
    d_dur     = in_data.tone_len;
    step      = 1'b0;
    nidx      = '0;
    last      = '0;
    nfreq     = '0;
    case (in_data.operation)
      OP_TICK: begin
        if (armed_r) begin
          if (remain_r > 20'd1) begin
            d_remain = remain_r - 20'd1;
          end else begin
            d_armed = 1'b0;
            d_remain = '0;
            d_pulse = '0;
            d_tone_on = 1'b0;
          end
        end
        if (kind_r != PAT_NONE) begin
          if (gap_r > 8'd1) begin
            d_gap = gap_r - 8'd1;
          end else begin
            d_gap = '0;
            step = 1'b1;
          end
        end
      end
      OP_PLAY: begin
        if (!enable_r) begin
          d_status = STS_NOEN;
        end else if (in_data.tone_freq < FREQ_MIN || in_data.tone_freq > FREQ_MAX ||
                     in_data.duty_percent > PCT) begin
          d_status = STS_INVAL;
        end else begin
          d_req = 1'b1;
        end
      end
      OP_STOP: begin
        if (!enable_r) begin
          d_status = STS_NOEN;
        end else begin
          d_armed = 1'b0;
          d_remain = '0;
          d_pulse = '0;
          d_tone_on = 1'b0;
        end
      end
      OP_SUCCESS, OP_ERROR, OP_WARNING: begin
        if (!enable_r) begin
          d_status = STS_NOEN;
        end else begin
          d_armed = 1'b0;
          d_remain = '0;
          d_pulse = '0;
          d_tone_on = 1'b0;
          d_kind = 2'(in_data.operation - 3'd2);
          d_index = '0;
          d_gap = '0;
          step = 1'b1;
        end
      end
      default: begin
        d_status = STS_INVAL;
      end
    endcase

    // pattern step: pick the note and advance the sequence
    if (step) begin
      d_duty = NOTE_DUTY;
      case (d_kind)
        PAT_SUCCESS: begin
          d_dur = NOTE_SHORT_MS;
          if (d_index == 2'd0) begin
            nfreq = {1'b0, note_hi_r};
            d_index = 2'd1;
            d_gap = GAP_SHORT;
          end else begin
            nfreq = {1'b0, note_mid_r};
            d_kind = PAT_NONE;
            d_index = '0;
            d_gap = '0;
          end
        end
        PAT_ERROR, PAT_WARNING: begin
          d_dur = NOTE_LONG_MS;
          nfreq = {1'b0, note_lo_r};
          last = (d_kind == PAT_ERROR) ? 2'd3 : 2'd2;
          nidx = d_index + 2'd1;
          if (nidx < last) begin
            d_index = nidx;
            d_gap = GAP_LONG;
          end else begin
            d_kind = PAT_NONE;
            d_index = '0;
            d_gap = '0;
          end
        end
        default: begin
          d_kind = PAT_NONE;
          d_index = '0;
          d_gap = '0;
        end
      endcase
      d_freq = nfreq;
      d_req = enable_r && nfreq >= FREQ_MIN && nfreq <= FREQ_MAX;
    end
  end

  // divider operand selection
  always_comb begin
    div_start    = 1'b0;
    div_dividend = NS_PER_S;
    div_divisor  = DIV_VW'(PCT);
    case (state_r)
      ST_IDLE: begin
        div_start    = accept && d_req;
        div_dividend = DIV_DW'(d_duty * volume_r);
      end
      ST_SCALE: begin
        div_start    = div_done;
        div_dividend = NS_PER_S;
        div_divisor  = freq_r;
      end
      ST_MUL: begin
        div_start    = 1'b1;
        div_dividend = DIV_DW'(per_r * scaled_r);
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  bzc_div #(
    .DW (DIV_DW),
    .VW (DIV_VW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quo)
  );

  // sequencer next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (accept) state_nxt = d_req ? ST_SCALE : ST_FIN;
      ST_SCALE: if (div_done) state_nxt = ST_PER;
      ST_PER:   if (div_done) state_nxt = ST_MUL;
      ST_MUL:   state_nxt = ST_PUL;
      ST_PUL:   if (div_done) state_nxt = ST_FIN;
      ST_FIN:   state_nxt = ST_OUT;
      ST_OUT:   if (!out_stall) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // control state, registers and tone state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r    <= 1'b0;
      volume_r    <= VOLUME_RST;
      note_hi_r   <= NOTE_HI_RST;
      note_mid_r  <= NOTE_MID_RST;
      note_lo_r   <= NOTE_LO_RST;
      tone_on_r   <= 1'b0;
      period_r    <= '0;
      pulse_r     <= '0;
      armed_r     <= 1'b0;
      remain_r    <= '0;
      kind_r      <= PAT_NONE;
      index_r     <= '0;
      gap_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr) begin
        case (paddr[4:2])
          REG_ENABLE: begin
            if (pwdata[0] && !enable_r) begin
              pulse_r   <= '0;
              tone_on_r <= 1'b0;
            end
            enable_r <= pwdata[0];
          end
          REG_VOLUME:   if (pwdata[6:0] <= PCT[6:0]) volume_r <= pwdata[6:0];
          REG_NOTE_HI:  note_hi_r  <= pwdata[14:0];
          REG_NOTE_MID: note_mid_r <= pwdata[14:0];
          REG_NOTE_LO:  note_lo_r  <= pwdata[14:0];
          default: ;
        endcase
      end
      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            tone_on_r <= d_tone_on;
            pulse_r   <= d_pulse;
            armed_r   <= d_armed;
            remain_r  <= d_remain;
            kind_r    <= d_kind;
            index_r   <= d_index;
            gap_r     <= d_gap;
          end
        end
        ST_PUL: begin
          if (div_done) begin
            period_r  <= per_r;
            pulse_r   <= div_quo[25:0];
            tone_on_r <= 1'b1;
            if (dur_r != '0) begin
              armed_r  <= 1'b1;
              remain_r <= dur_r;
            end
          end
        end
        ST_FIN: out_valid_r <= 1'b1;
        ST_OUT: if (!out_stall) out_valid_r <= 1'b0;
        default: ;
      endcase
    end
  end

  // per-beat payload
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && accept) begin
      status_r  <= d_status;
      old_per_r <= period_r;
      old_pul_r <= pulse_r;
      freq_r    <= d_freq;
      dur_r     <= d_dur;
    end
    if (state_r == ST_SCALE && div_done) scaled_r <= div_quo[6:0];
    if (state_r == ST_PER && div_done) per_r <= div_quo[25:0];
    if (state_r == ST_FIN) begin
      out_data_r.status      <= status_r;
      out_data_r.pwm_period  <= period_r;
      out_data_r.pwm_pulse   <= pulse_r;
      out_data_r.pwm_updated <= (period_r != old_per_r) || (pulse_r != old_pul_r);
      out_data_r.playing     <= enable_r && tone_on_r;
    end
  end

  // register read back
  always_comb begin
    prdata = '0;
    case (paddr[4:2])
      REG_ENABLE:   prdata = {31'd0, enable_r};
      REG_VOLUME:   prdata = {25'd0, volume_r};
      REG_NOTE_HI:  prdata = {17'd0, note_hi_r};
      REG_NOTE_MID: prdata = {17'd0, note_mid_r};
      REG_NOTE_LO:  prdata = {17'd0, note_lo_r};
      default:      prdata = '0;
    endcase
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `ASSERT_IMPL(a_out_in_out_state, out_valid_r, state_r == ST_OUT, "result outside out state")
  `ASSERT_IMPL(a_silent_no_pulse, !tone_on_r, pulse_r == '0, "pulse nonzero while silent")
  `ASSERT_IMPL(a_disarmed_clear, !armed_r, remain_r == '0, "countdown left while disarmed")
  `ASSERT_IMPL(a_no_pattern_clear, kind_r == PAT_NONE, index_r == '0 && gap_r == '0, "stale pattern")

endmodule

### src/bzc_div.sv
// ---------------------------------------------------------------------------
// bzc_div
// bit-serial restoring divider, one quotient bit per cycle
// ---------------------------------------------------------------------------
module bzc_div #(
  parameter int DW = 34,
  parameter int VW = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quotient
);

  localparam int CW = $clog2(DW);
  localparam logic [CW-1:0] LAST = CW'(DW - 1);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [DW-1:0] quo_r, quo_nxt;
  logic [VW-1:0] rem_r, rem_nxt;
  logic [VW-1:0] div_r, div_nxt;
  logic [VW:0]   trial;
  logic          ge;

  // one trial subtract per cycle
  assign trial = {rem_r, quo_r[DW-1]};
  assign ge    = trial >= {1'b0, div_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      quo_nxt  = dividend;
      rem_nxt  = '0;
      div_nxt  = divisor;
    end else if (busy_r) begin
      quo_nxt = {quo_r[DW-2:0], ge};
      rem_nxt = ge ? VW'(trial - {1'b0, div_r}) : trial[VW-1:0];
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == LAST) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // data path
  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    div_r <= div_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

### sim/buzzer_tone_pattern_controller_chk.sv
// ---------------------------------------------------------------------------
// buzzer_tone_pattern_controller_chk
// Watches the input, result and register ports of the buzzer controller.
// A local model of the tone, auto-stop and pattern state predicts every
// result beat, and the checker compares each result with its prediction.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module buzzer_tone_pattern_controller_chk (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  bzc_pkg::in_beat_t  in_data,
  input  logic               out_valid,
  input  logic               out_stall,
  input  bzc_pkg::out_beat_t out_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic               pready,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  input  logic               done,
  output int                 errors
);

  import bzc_pkg::*;

  // register copy
  logic        en;
  logic [6:0]  vol;
  logic [14:0] note_hi, note_mid, note_lo;

  // tone and pattern state
  logic        tone_on;
  logic [25:0] per_ns, pul_ns;
  logic        armed;
  logic [19:0] remain_ms;
  logic [1:0]  pat_kind, pat_idx;
  logic [7:0]  gap_ms;

  out_beat_t result_q[$];
  int        mismatches;

  // tone request; status of the request
  function automatic logic [1:0] tone_request(logic [15:0] f, logic [7:0] d,
                                              logic [19:0] dur);
    int unsigned scaled, per;
    longint unsigned pul;
    if (!en) return STS_NOEN;
    if (f < FREQ_MIN || f > FREQ_MAX || d > PCT) return STS_INVAL;
    scaled = 32'(d) * 32'(vol) / 32'(PCT);
    per    = 32'd1000000000 / 32'(f);
    pul    = 64'(per) * 64'(scaled) / 64'(PCT);
    per_ns  = per[25:0];
    pul_ns  = pul[25:0];
    tone_on = 1'b1;
    if (dur != 0) begin
      armed     = 1'b1;
      remain_ms = dur;
    end
    return STS_OK;
  endfunction

  function automatic void silence();
    armed     = 1'b0;
    remain_ms = '0;
    pul_ns    = '0;
    tone_on   = 1'b0;
  endfunction

  function automatic void end_pattern();
    pat_kind = PAT_NONE;
    pat_idx  = '0;
    gap_ms   = '0;
  endfunction

  // next note of the running pattern
  function automatic void play_note();
    logic [1:0] last;
    if (pat_kind == PAT_SUCCESS) begin
      if (pat_idx == 0) begin
        void'(tone_request({1'b0, note_hi}, NOTE_DUTY, NOTE_SHORT_MS));
        pat_idx = 2'd1;
        gap_ms  = GAP_SHORT;
      end else begin
        void'(tone_request({1'b0, note_mid}, NOTE_DUTY, NOTE_SHORT_MS));
        end_pattern();
      end
    end else if (pat_kind == PAT_ERROR || pat_kind == PAT_WARNING) begin
      last = (pat_kind == PAT_ERROR) ? 2'd3 : 2'd2;
      void'(tone_request({1'b0, note_lo}, NOTE_DUTY, NOTE_LONG_MS));
      pat_idx = pat_idx + 2'd1;
      if (pat_idx < last) gap_ms = GAP_LONG;
      else end_pattern();
    end else begin
      end_pattern();
    end
  endfunction

  // one millisecond: countdown first, then pattern gap
  function automatic void tick_ms();
    if (armed) begin
      if (remain_ms > 1) remain_ms = remain_ms - 1;
      else silence();
    end
    if (pat_kind != PAT_NONE) begin
      if (gap_ms > 1) gap_ms = gap_ms - 1;
      else begin
        gap_ms = '0;
        play_note();
      end
    end
  endfunction

  function automatic out_beat_t predict_result(in_beat_t b);
    out_beat_t   r;
    logic [25:0] old_per, old_pul;
    old_per  = per_ns;
    old_pul  = pul_ns;
    r.status = STS_OK;
    case (b.operation)
      OP_TICK: tick_ms();
      OP_PLAY: r.status = tone_request(b.tone_freq, b.duty_percent, b.tone_len);
      OP_STOP: begin
        if (!en) r.status = STS_NOEN;
        else silence();
      end
      OP_SUCCESS, OP_ERROR, OP_WARNING: begin
        if (!en) r.status = STS_NOEN;
        else begin
          silence();
          end_pattern();
          pat_kind = 2'(b.operation - 3'd2);
          play_note();
        end
      end
      default: r.status = STS_INVAL;
    endcase
    r.pwm_period  = per_ns;
    r.pwm_pulse   = pul_ns;
    r.pwm_updated = (per_ns != old_per) || (pul_ns != old_pul);
    r.playing     = en && tone_on;
    return r;
  endfunction

  function automatic void write_reg(logic [2:0] idx, logic [31:0] data);
    logic [14:0] v;
    v = data[14:0];
    case (idx)
      REG_ENABLE: begin
        if (v[0] && !en) begin
          pul_ns  = '0;
          tone_on = 1'b0;
        end
        en = v[0];
      end
      REG_VOLUME: if (v[6:0] <= PCT) vol = v[6:0];
      REG_NOTE_HI:  note_hi  = v;
      REG_NOTE_MID: note_mid = v;
      REG_NOTE_LO:  note_lo  = v;
      default: ;
    endcase
  endfunction

  function automatic void check_field(string name, longint unsigned exp_v,
                                      longint unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      mismatches++;
    end
  endfunction

  // watch the three ports
  always @(posedge clk) begin
    out_beat_t e;
    if (!rst_n) begin
      en = 1'b0; vol = VOLUME_RST;
      note_hi = NOTE_HI_RST; note_mid = NOTE_MID_RST; note_lo = NOTE_LO_RST;
      tone_on = 1'b0; per_ns = '0; pul_ns = '0; armed = 1'b0; remain_ms = '0;
      end_pattern();
      result_q.delete();
      mismatches = 0;
    end else begin
      if (psel && penable && pwrite && pready) write_reg(paddr[4:2], pwdata);
      if (in_valid && !in_stall) result_q.push_back(predict_result(in_data));
      if (out_valid && !out_stall) begin
        if (result_q.size() == 0) begin
          $error("result beat with no prediction pending");
          mismatches++;
        end else begin
          e = result_q.pop_front();
          check_field("status", e.status, out_data.status);
          check_field("pwm_period", e.pwm_period, out_data.pwm_period);
          check_field("pwm_pulse", e.pwm_pulse, out_data.pwm_pulse);
          check_field("pwm_updated", e.pwm_updated, out_data.pwm_updated);
          check_field("playing", e.playing, out_data.playing);
        end
      end
    end
    // unanswered beats count as failures once stimulus is over
    errors = mismatches + (done ? result_q.size() : 0);
  end

endmodule

### sim/buzzer_tone_pattern_controller_tb.sv
// ---------------------------------------------------------------------------
// buzzer_tone_pattern_controller_tb
// Drives commands and millisecond ticks into the buzzer controller through
// several register settings, with random gaps and result back-pressure.
// Checking is done by the checker module beside the block.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module buzzer_tone_pattern_controller_tb;
  import bzc_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_beat_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_beat_t   out_data;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        done = 1'b0;
  logic        calm = 1'b0;
  int          errors;
  int          beats_sent = 0, beats_back = 0, reg_writes = 0;
  int          rx_hold = 0;
  bit          hold_done = 0;

  buzzer_tone_pattern_controller u_top (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall,
    .out_data, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  buzzer_tone_pattern_controller_chk u_chk (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall,
    .out_data, .psel, .penable, .pwrite, .pready, .paddr, .pwdata, .done, .errors
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit
  initial begin
    #30ms;
    $display("FAIL");
    $finish;
  end

  // result side: random stalls, one long hold-off so the block backs up
  always @(negedge clk) begin
    if (!hold_done && beats_sent >= 300) begin
      hold_done = 1;
      rx_hold = 400;
    end
    if (rx_hold > 0) begin
      rx_hold = rx_hold - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= calm ? 1'b0 : ($urandom_range(99) < 27);
    end
  end

  always @(posedge clk)
    if (rst_n && out_valid && !out_stall) beats_back++;

  task automatic reg_write(logic [2:0] idx, logic [31:0] data);
    @(negedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    reg_writes++;
  endtask

  // called at a falling edge; leaves the beat accepted, valid still high
  task automatic send_beat(in_beat_t b);
    int gap;
    if (!calm && $urandom_range(99) < 27) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 6);
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    beats_sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    if (in_valid) in_valid <= 1'b0;
    while (beats_back != beats_sent) @(negedge clk);
  endtask

  function automatic in_beat_t mk(logic [2:0] op, logic [15:0] f, logic [7:0] d,
                                  logic [19:0] dur);
    in_beat_t b;
    b.operation = op; b.tone_freq = f; b.duty_percent = d; b.tone_len = dur;
    return b;
  endfunction

  // mostly ticks and well-formed requests, some out-of-range noise
  function automatic in_beat_t random_beat();
    in_beat_t    b;
    logic [63:0] raw;
    int          pick;
    raw = {$urandom, $urandom};
    b = raw[$bits(in_beat_t)-1:0];
    pick = $urandom_range(99);
    if (pick < 70) b.operation = OP_TICK;
    else if (pick < 82) begin
      b.operation = OP_PLAY;
      b.tone_freq = 16'($urandom_range(20, 20000));
      b.duty_percent = 8'($urandom_range(0, 100));
      case ($urandom_range(3))
        0: b.tone_len = '0;
        1, 2: b.tone_len = 20'($urandom_range(1, 300));
        default: ;
      endcase
    end else if (pick < 86) b.operation = OP_STOP;
    else if (pick < 89) b.operation = OP_SUCCESS;
    else if (pick < 92) b.operation = OP_ERROR;
    else if (pick < 95) b.operation = OP_WARNING;
    else if (pick < 98) b.operation = OP_PLAY;
    else b.operation = 3'($urandom_range(6, 7));
    return b;
  endfunction

  task automatic random_phase(int n);
    for (int i = 0; i < n; i++) send_beat(random_beat());
    drain();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // disabled: every command refused, the tick still accepted
    send_beat(mk(OP_TICK, 16'd0, 8'd0, 20'd0));
    send_beat(mk(OP_PLAY, 16'd440, 8'd50, 20'd10));
    send_beat(mk(OP_STOP, 16'd0, 8'd0, 20'd0));
    send_beat(mk(OP_SUCCESS, 16'd0, 8'd0, 20'd0));
    send_beat(mk(3'd6, 16'd0, 8'd0, 20'd0));
    drain();
    reg_write(REG_ENABLE, 32'd1);

    // field extremes and each operation
    send_beat(mk(OP_PLAY, 16'd19, 8'd50, 20'd0));
    send_beat(mk(OP_PLAY, 16'd20, 8'd100, 20'd0));
    send_beat(mk(OP_PLAY, 16'd20000, 8'd0, 20'd0));
    send_beat(mk(OP_PLAY, 16'd20001, 8'd50, 20'd0));
    send_beat(mk(OP_PLAY, 16'hffff, 8'hff, 20'hfffff));
    send_beat(mk(OP_PLAY, 16'd1000, 8'd101, 20'd5));
    send_beat(mk(OP_PLAY, 16'd1000, 8'd100, 20'hfffff));
    send_beat(mk(OP_PLAY, 16'd777, 8'd33, 20'd0));
    send_beat(mk(OP_TICK, 16'hffff, 8'hff, 20'hfffff));
    send_beat(mk(OP_STOP, 16'd0, 8'd0, 20'd0));
    send_beat(mk(OP_PLAY, 16'd3000, 8'd70, 20'd1));
    send_beat(mk(OP_TICK, 16'd0, 8'd0, 20'd0));
    send_beat(mk(OP_SUCCESS, 16'd0, 8'd0, 20'd0));
    send_beat(mk(OP_TICK, 16'd0, 8'd0, 20'd0));
    send_beat(mk(OP_ERROR, 16'd0, 8'd0, 20'd0));
    send_beat(mk(OP_STOP, 16'd0, 8'd0, 20'd0));
    send_beat(mk(OP_WARNING, 16'd0, 8'd0, 20'd0));
    send_beat(mk(3'd7, 16'd0, 8'd0, 20'd0));
    drain();

    // register settings, extremes among them
    random_phase(300);
    reg_write(REG_VOLUME, 32'd0);
    reg_write(REG_NOTE_HI, 32'd20000);
    reg_write(REG_NOTE_MID, 32'd20);
    random_phase(250);
    reg_write(REG_VOLUME, 32'd100);
    reg_write(REG_NOTE_LO, 32'd20);
    reg_write(REG_NOTE_HI, 32'hffff_7fff);
    calm = 1'b1;
    random_phase(300);
    calm = 1'b0;
    reg_write(REG_VOLUME, 32'd127);
    reg_write(REG_NOTE_LO, 32'd19);
    reg_write(REG_NOTE_MID, 32'd0);
    random_phase(250);
    reg_write(REG_ENABLE, 32'd0);
    random_phase(100);
    reg_write(REG_ENABLE, 32'hffff_fffe);
    reg_write(REG_ENABLE, 32'd1);
    reg_write(REG_VOLUME, $urandom_range(1, 99));
    reg_write(REG_NOTE_HI, $urandom_range(20, 20000));
    reg_write(REG_NOTE_MID, $urandom_range(20, 20000));
    reg_write(REG_NOTE_LO, 32'd20000);
    random_phase(300);
    reg_write(REG_VOLUME, 32'd101);
    reg_write(REG_NOTE_LO, $urandom_range(20, 20000));
    random_phase(330);

    repeat (150) @(negedge clk);
    done = 1'b1;
    @(negedge clk);
    $display("covered %0d command and tick beats, %0d results, %0d register writes",
             beats_sent, beats_back, reg_writes);
    $display("settings swept volume 0..100 and note limits, with a long result hold-off");
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
